>>> hw/rtl/ebes_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ebes_pkg
// Shared types and constants of the equirectangular elevation sampler.
// ----------------------------------------------------------------------------
package ebes_pkg;

  localparam int GRID_AW    = 21;
  localparam int GRID_WORDS = 1 << GRID_AW;
  localparam int ROWBASE_W  = 23;
  localparam int OUT_DEPTH  = 8;
  localparam int OUT_PW     = 3;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic REG_GRID_COLS = 1'b0;
  localparam logic REG_GRID_ROWS = 1'b1;

  localparam logic [11:0] GRID_COLS_RST = 12'd2048;
  localparam logic [10:0] GRID_ROWS_RST = 11'd1024;

  localparam logic [1:0] PH_TL = 2'd0;
  localparam logic [1:0] PH_TR = 2'd1;
  localparam logic [1:0] PH_BL = 2'd2;
  localparam logic [1:0] PH_BR = 2'd3;

  localparam logic signed [51:0] INV_PI_Q32    = 52'sd1367130551;
  localparam logic signed [51:0] INV_TWOPI_Q32 = 52'sd683565276;
  localparam logic signed [51:0] HALF_Q48      = 52'sd140737488355328;
  localparam logic [67:0]        M_PER_KM      = 68'd1000;

  typedef struct packed {
    logic               cmd;
    logic [20:0]        idx;
    logic signed [21:0] elev;
  } tag_t;

  typedef struct packed {
    logic                 cmd;
    logic [20:0]          idx;
    logic signed [21:0]   elev;
    logic [11:0]          x0;
    logic [11:0]          x1;
    logic [15:0]          fx;
    logic [15:0]          fy;
    logic [GRID_AW-1:0]   rb0;
    logic [GRID_AW-1:0]   rb1;
  } coord_t;

  typedef struct packed {
    logic signed [21:0] v00;
    logic signed [21:0] v10;
    logic signed [21:0] v01;
    logic signed [21:0] v11;
    logic [15:0]        fx;
    logic [15:0]        fy;
    logic               zero;
  } interp_t;

  function automatic logic load_in_range(input logic [20:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return (wide >> GRID_AW) == 32'd0;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ebes_coord.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ebes_coord
// Six-stage coordinate pipeline: angles to grid cell, fractions and row bases.
// ----------------------------------------------------------------------------
module ebes_coord (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                adv,
  input  wire logic                in_valid,
  input  wire logic                cmd,
  input  wire logic signed [18:0]  lat_rad,
  input  wire logic signed [19:0]  lon_rad,
  input  wire logic [20:0]         load_index,
  input  wire logic signed [21:0]  load_elev_km,
  input  wire logic [11:0]         cols,
  input  wire logic [10:0]         rows,
  output logic                     out_vld,
  output ebes_pkg::coord_t         item
);

  localparam int ROWBASE_W_L = ebes_pkg::ROWBASE_W;

  logic [5:0]           vld;
  ebes_pkg::tag_t       tag [5];

  logic signed [51:0]   ply1, plx1;
  logic signed [51:0]   t2, s2;
  logic signed [62:0]   my3, mx3;
  logic signed [31:0]   pxa4;
  logic [26:0]          py4;
  logic [11:0]          x05;
  logic [15:0]          fx5;
  logic [10:0]          y05;
  logic [15:0]          fy5;

  logic [11:0]          cols_m1;
  logic [10:0]          rows_m1;
  logic signed [31:0]   wx;
  logic signed [31:0]   pymax;
  logic signed [31:0]   pxs, pys, pxc;
  logic [12:0]          x0p1;
  logic [11:0]          y0p1;
  logic [11:0]          x1c;
  logic [10:0]          y1c;
  logic [ROWBASE_W_L-1:0] prod0, prod1;

  assign cols_m1 = cols - 12'd1;
  assign rows_m1 = rows - 11'd1;
  assign wx      = 32'({cols, 16'b0});
  assign pymax   = 32'({rows_m1, 16'b0});
  assign pxs     = 32'($signed(mx3[62:32]));
  assign pys     = 32'($signed(my3[62:32]));

  always_comb begin
    if (pxa4 < 0) begin
      pxc = '0;
    end else if (pxa4 >= wx) begin
      pxc = wx - 32'sd1;
    end else begin
      pxc = pxa4;
    end
  end

  assign x0p1  = {1'b0, x05} + 13'd1;
  assign y0p1  = {1'b0, y05} + 12'd1;
  assign x1c   = (x0p1 == {1'b0, cols}) ? '0 : x0p1[11:0];
  assign y1c   = (y0p1 < {1'b0, rows}) ? y0p1[10:0] : rows_m1;
  assign prod0 = {12'b0, y05} * {11'b0, cols};
  assign prod1 = {12'b0, y1c} * {11'b0, cols};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag[0] <= '{cmd: cmd, idx: load_index, elev: load_elev_km};
      for (int i = 1; i < 5; i++) begin
        tag[i] <= tag[i-1];
      end
      ply1 <= 52'(lat_rad) * ebes_pkg::INV_PI_Q32;
      plx1 <= 52'(lon_rad) * ebes_pkg::INV_TWOPI_Q32;
      t2   <= ebes_pkg::HALF_Q48 - ply1;
      s2   <= plx1 + ebes_pkg::HALF_Q48;
      my3  <= 63'(t2) * 63'($signed({1'b0, rows_m1}));
      mx3  <= 63'(s2) * 63'($signed({1'b0, cols_m1}));
      if (pxs < 0) begin
        pxa4 <= pxs + wx;
      end else if (pxs >= wx) begin
        pxa4 <= pxs - wx;
      end else begin
        pxa4 <= pxs;
      end
      if (pys < 0) begin
        py4 <= '0;
      end else if (pys > pymax) begin
        py4 <= pymax[26:0];
      end else begin
        py4 <= pys[26:0];
      end
      x05 <= pxc[27:16];
      fx5 <= pxc[15:0];
      y05 <= py4[26:16];
      fy5 <= py4[15:0];
      item.cmd  <= tag[4].cmd;
      item.idx  <= tag[4].idx;
      item.elev <= tag[4].elev;
      item.x0   <= x05;
      item.x1   <= x1c;
      item.fx   <= fx5;
      item.fy   <= fy5;
      item.rb0  <= prod0[ebes_pkg::GRID_AW-1:0];
      item.rb1  <= prod1[ebes_pkg::GRID_AW-1:0];
    end
  end

  assign out_vld = vld[5];

endmodule
`default_nettype wire

>>> hw/rtl/ebes_interp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ebes_interp
// Eight-stage bilinear blend of four neighbours and scaling to Q.8 metres.
// ----------------------------------------------------------------------------
module ebes_interp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  input  wire ebes_pkg::interp_t  req,
  output logic                    res_valid,
  output logic signed [23:0]      res
);

  logic [7:0]          vld;
  logic [6:0]          zero;

  logic signed [39:0]  pt1, pb1;
  logic signed [21:0]  v00_1, v01_1;
  logic [15:0]         fy1, fy2, fy3;
  logic signed [39:0]  top2, bot2;
  logic signed [40:0]  dv3;
  logic signed [39:0]  top3, top4;
  logic signed [57:0]  pv4;
  logic signed [57:0]  val5;
  logic [57:0]         mag6;
  logic                neg6, neg7;
  logic [23:0]         q7;

  logic signed [22:0]  d_top, d_bot;
  logic [67:0]         scaled;

  assign d_top  = 23'(req.v10) - 23'(req.v00);
  assign d_bot  = 23'(req.v11) - 23'(req.v01);
  assign scaled = 68'(mag6) * ebes_pkg::M_PER_KM;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[6:0], req_valid};
    end
  end

  always_ff @(posedge clk) begin
    zero  <= {zero[5:0], req.zero};
    pt1   <= 40'(d_top) * 40'($signed({1'b0, req.fx}));
    pb1   <= 40'(d_bot) * 40'($signed({1'b0, req.fx}));
    v00_1 <= req.v00;
    v01_1 <= req.v01;
    fy1   <= req.fy;
    top2  <= (40'(v00_1) <<< 16) + pt1;
    bot2  <= (40'(v01_1) <<< 16) + pb1;
    fy2   <= fy1;
    dv3   <= 41'(bot2) - 41'(top2);
    top3  <= top2;
    fy3   <= fy2;
    pv4   <= 58'(dv3) * 58'($signed({1'b0, fy3}));
    top4  <= top3;
    val5  <= (58'(top4) <<< 16) + pv4;
    neg6  <= val5 < 0;
    mag6  <= (val5 < 0) ? 58'(-val5) : 58'(val5);
    neg7  <= neg6;
    q7    <= scaled[63:40];
    if (zero[6]) begin
      res <= '0;
    end else if (neg7) begin
      res <= -$signed(q7);
    end else begin
      res <= $signed(q7);
    end
  end

  assign res_valid = vld[7];

endmodule
`default_nettype wire

>>> hw/rtl/equirect_bilinear_elevation_sampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// equirect_bilinear_elevation_sampler
// Elevation grid memory with bilinear sampling at latitude and longitude.
// ----------------------------------------------------------------------------
// A load request writes one grid word and gives no result. A sample request
// reads its four neighbours one per cycle from the single-port grid memory,
// and the next request is taken as its last neighbour is read; loads go one
// per cycle while no sample is being read. Sample results appear in request
// order, and read 0 until a load has been taken since reset. The grid memory
// is not cleared; only written entries may be sampled. Up to eight sample
// results are held when the output stalls.
module equirect_bilinear_elevation_sampler (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                cmd,
  input  wire logic signed [18:0]  lat_rad,
  input  wire logic signed [19:0]  lon_rad,
  input  wire logic [20:0]         load_index,
  input  wire logic signed [21:0]  load_elev_km,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [23:0]       elev_m,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [11:0]         cfg_data
);

  localparam int AW = ebes_pkg::GRID_AW;
  localparam int PW = ebes_pkg::OUT_PW;

  logic [11:0]            grid_cols;
  logic [10:0]            grid_rows;
  logic [11:0]            cols_eff;
  logic [10:0]            rows_eff;
  logic                   grid_loaded;

  logic                   c_vld;
  ebes_pkg::coord_t       c_item;
  logic                   adv;
  logic                   take;
  logic                   take_ok;

  logic                   job_valid;
  logic                   job_cmd;
  logic [1:0]             job_phase;
  logic [20:0]            job_idx;
  logic signed [21:0]     job_elev;
  logic [11:0]            job_x0, job_x1;
  logic [AW-1:0]          job_rb0, job_rb1;
  logic [15:0]            job_fx, job_fy;
  logic                   job_zero;
  logic                   job_sample;

  logic signed [21:0]     grid_mem [ebes_pkg::GRID_WORDS];
  logic signed [21:0]     mem_q;
  logic                   mem_we;
  logic                   mem_re;
  logic [AW-1:0]          mem_addr;
  logic [AW-1:0]          row_base;
  logic [11:0]            col_sel;

  logic                   ret_vld;
  logic [1:0]             ret_phase;
  logic [15:0]            ret_fx, ret_fy;
  logic                   ret_zero;
  logic signed [21:0]     v00, v10, v01;

  logic                   ip_valid;
  ebes_pkg::interp_t      ip_req;
  logic                   res_valid;
  logic signed [23:0]     res;

  logic signed [23:0]     fifo [ebes_pkg::OUT_DEPTH];
  logic [PW-1:0]          wr_ptr, rd_ptr;
  logic [PW:0]            fifo_count;
  logic [PW:0]            pending;
  logic                   pop;
  logic                   inc;

  assign cols_eff = (grid_cols == '0) ? 12'd1 : grid_cols;
  assign rows_eff = (grid_rows == '0) ? 11'd1 : grid_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= ebes_pkg::GRID_COLS_RST;
      grid_rows <= ebes_pkg::GRID_ROWS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ebes_pkg::REG_GRID_COLS: grid_cols <= cfg_data;
        ebes_pkg::REG_GRID_ROWS: grid_rows <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  ebes_coord u_coord (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (in_valid),
    .cmd          (cmd),
    .lat_rad      (lat_rad),
    .lon_rad      (lon_rad),
    .load_index   (load_index),
    .load_elev_km (load_elev_km),
    .cols         (cols_eff),
    .rows         (rows_eff),
    .out_vld      (c_vld),
    .item         (c_item)
  );

  // sequencer: one load per cycle while no sample is reading, four neighbour reads per sample
  assign job_sample = job_valid && (job_cmd == ebes_pkg::CMD_SAMPLE);
  assign take_ok    = !job_sample || (job_phase == ebes_pkg::PH_BR);
  assign take       = c_vld && take_ok &&
                      ((c_item.cmd == ebes_pkg::CMD_LOAD) ||
                       (pending < (PW+1)'(ebes_pkg::OUT_DEPTH)));
  assign adv        = !c_vld || take;
  assign in_stall   = rst || !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid   <= 1'b0;
      job_phase   <= ebes_pkg::PH_TL;
      grid_loaded <= 1'b0;
    end else begin
      if (take) begin
        job_valid <= 1'b1;
        job_phase <= ebes_pkg::PH_TL;
        if ((c_item.cmd == ebes_pkg::CMD_LOAD) && ebes_pkg::load_in_range(c_item.idx)) begin
          grid_loaded <= 1'b1;
        end
      end else if (job_sample && (job_phase != ebes_pkg::PH_BR)) begin
        job_phase <= job_phase + 2'd1;
      end else begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_cmd  <= c_item.cmd;
      job_idx  <= c_item.idx;
      job_elev <= c_item.elev;
      job_x0   <= c_item.x0;
      job_x1   <= c_item.x1;
      job_rb0  <= c_item.rb0;
      job_rb1  <= c_item.rb1;
      job_fx   <= c_item.fx;
      job_fy   <= c_item.fy;
      job_zero <= !grid_loaded;
    end
  end

  assign row_base = job_phase[1] ? job_rb1 : job_rb0;
  assign col_sel  = job_phase[0] ? job_x1 : job_x0;
  assign mem_we   = job_valid && (job_cmd == ebes_pkg::CMD_LOAD) &&
                    ebes_pkg::load_in_range(job_idx);
  assign mem_re   = job_sample;
  assign mem_addr = (job_cmd == ebes_pkg::CMD_LOAD) ? job_idx[AW-1:0]
                                                    : row_base + AW'(col_sel);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_addr] <= job_elev;
    end else if (mem_re) begin
      mem_q <= grid_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ret_vld <= 1'b0;
    end else begin
      ret_vld <= job_sample;
    end
  end

  always_ff @(posedge clk) begin
    ret_phase <= job_phase;
    ret_fx    <= job_fx;
    ret_fy    <= job_fy;
    ret_zero  <= job_zero;
    if (ret_vld) begin
      case (ret_phase)
        ebes_pkg::PH_TL: v00 <= mem_q;
        ebes_pkg::PH_TR: v10 <= mem_q;
        ebes_pkg::PH_BL: v01 <= mem_q;
        default: ;
      endcase
    end
  end

  assign ip_valid    = ret_vld && (ret_phase == ebes_pkg::PH_BR);
  assign ip_req.v00  = v00;
  assign ip_req.v10  = v10;
  assign ip_req.v01  = v01;
  assign ip_req.v11  = mem_q;
  assign ip_req.fx   = ret_fx;
  assign ip_req.fy   = ret_fy;
  assign ip_req.zero = ret_zero;

  ebes_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .req_valid (ip_valid),
    .req       (ip_req),
    .res_valid (res_valid),
    .res       (res)
  );

  // result queue; pending counts samples taken and not yet delivered
  assign pop       = out_valid && !out_stall;
  assign inc       = take && (c_item.cmd == ebes_pkg::CMD_SAMPLE);
  assign out_valid = fifo_count != '0;
  assign elev_m    = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
      pending    <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (res_valid && !pop) begin
        fifo_count <= fifo_count + (PW+1)'(1);
      end else if (!res_valid && pop) begin
        fifo_count <= fifo_count - (PW+1)'(1);
      end
      if (inc && !pop) begin
        pending <= pending + (PW+1)'(1);
      end else if (!inc && pop) begin
        pending <= pending - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      fifo[wr_ptr] <= res;
    end
  end

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= (PW+1)'(ebes_pkg::OUT_DEPTH))
    else $error("pending sample count exceeds queue depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (fifo_count < (PW+1)'(ebes_pkg::OUT_DEPTH)))
    else $error("result pushed into full queue");

  a_zero_unloaded: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !grid_loaded) |-> (elev_m == '0))
    else $error("nonzero result before any load");

endmodule
`default_nettype wire

>>> test/tb_equirect_bilinear_elevation_sampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_equirect_bilinear_elevation_sampler
// Self-checking bench for the bilinear elevation sampler. Grid loads and
// position samples are driven over the valid/stall request port with random
// gaps and output stalls. Accepted loads update a local grid copy, config
// writes set its size, and each sample queues the metres value it must return.
// Results are compared in order. Past the samples sent before any load, all
// four neighbour words of a sample are loaded first, so no later sample reads
// an unwritten word. Grid sizes run from zero and one up to the widest
// register values; one long output stall backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_equirect_bilinear_elevation_sampler;

  localparam longint RECIP_PI_Q32  = 64'sd1367130551;
  localparam longint RECIP_2PI_Q32 = 64'sd683565276;
  localparam longint MID_Q48       = 64'sd140737488355328;
  localparam longint Q16_ONE       = 64'sd65536;
  localparam int     LAT_SPAN      = 205887;
  localparam int     LON_SPAN      = 411775;
  localparam logic signed [21:0] ELEV_KM_MAX = 22'sh1FFFFF;
  localparam logic signed [21:0] ELEV_KM_MIN = 22'sh200000;
  localparam int     PHASE_REQUESTS = 50;
  localparam int     SETTLE_CYCLES  = 40;
  localparam int     LONG_HOLD      = 300;
  localparam int     MAX_REPORTS    = 10;
  localparam int     TIMEOUT        = 8000000;

  typedef struct packed {
    logic [20:0] a00;
    logic [20:0] a10;
    logic [20:0] a01;
    logic [20:0] a11;
    logic [15:0] fx;
    logic [15:0] fy;
  } cell_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                cmd;
  logic signed [18:0]  lat_rad;
  logic signed [19:0]  lon_rad;
  logic [20:0]         load_index;
  logic signed [21:0]  load_elev_km;
  logic                out_valid;
  logic                out_stall;
  logic signed [23:0]  elev_m;
  logic                cfg_we;
  logic                cfg_index;
  logic [11:0]         cfg_data;

  logic signed [21:0]  grid_model [int];
  bit                  grid_written [int];
  logic                grid_has_data;
  logic [11:0]         cols_setting;
  logic [10:0]         rows_setting;
  logic signed [23:0]  pending_elev [$];

  int  mismatches = 0;
  int  requests_sent = 0;
  int  holds_requested = 0;
  bit  tx_gaps_on = 1'b1;
  bit  rx_gaps_on = 1'b1;

  equirect_bilinear_elevation_sampler uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .lat_rad      (lat_rad),
    .lon_rad      (lon_rad),
    .load_index   (load_index),
    .load_elev_km (load_elev_km),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .elev_m       (elev_m),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic cell_t locate_cell(input longint lat, input longint lon);
    longint ncol, nrow, py, px, w, x0, y0, x1, y1;
    cell_t  c;
    ncol = longint'(cols_setting);
    nrow = longint'(rows_setting);
    if (ncol == 0) ncol = 1;
    if (nrow == 0) nrow = 1;
    py = ((MID_Q48 - lat * RECIP_PI_Q32) * (nrow - 1)) >>> 32;
    px = ((lon * RECIP_2PI_Q32 + MID_Q48) * (ncol - 1)) >>> 32;
    w = ncol * Q16_ONE;
    if (px < 0) px = px + w;
    else if (px >= w) px = px - w;
    if (px < 0) px = 0;
    if (px >= w) px = w - 1;
    if (py < 0) py = 0;
    if (py > (nrow - 1) * Q16_ONE) py = (nrow - 1) * Q16_ONE;
    x0 = px >>> 16;
    y0 = py >>> 16;
    x1 = (x0 + 1) % ncol;
    y1 = (y0 + 1 < nrow) ? y0 + 1 : nrow - 1;
    c.a00 = 21'(y0 * ncol + x0);
    c.a10 = 21'(y0 * ncol + x1);
    c.a01 = 21'(y1 * ncol + x0);
    c.a11 = 21'(y1 * ncol + x1);
    c.fx = px[15:0];
    c.fy = py[15:0];
    return c;
  endfunction

  function automatic logic signed [23:0] predict_elevation(input cell_t c);
    longint v00, v10, v01, v11, wx, wy, top, bot, val;
    longint unsigned mag, q;
    v00 = longint'(grid_model[c.a00]);
    v10 = longint'(grid_model[c.a10]);
    v01 = longint'(grid_model[c.a01]);
    v11 = longint'(grid_model[c.a11]);
    wx = longint'(c.fx);
    wy = longint'(c.fy);
    top = v00 * (Q16_ONE - wx) + v10 * wx;
    bot = v01 * (Q16_ONE - wx) + v11 * wx;
    val = top * (Q16_ONE - wy) + bot * wy;
    mag = (val < 0) ? -val : val;
    q = (mag * 64'd1000) >> 40;
    if (val < 0) q = -q;
    return q[23:0];
  endfunction

  function automatic int pick_gap(input bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic signed [18:0] pick_lat();
    if ($urandom_range(99) < 80) return 19'($urandom_range(2 * LAT_SPAN) - LAT_SPAN);
    return 19'($urandom);
  endfunction

  function automatic logic signed [19:0] pick_lon();
    if ($urandom_range(99) < 80) return 20'($urandom_range(2 * LON_SPAN) - LON_SPAN);
    return 20'($urandom);
  endfunction

  // track grid size, memory contents and expected results of accepted requests
  always @(posedge clk) begin
    if (rst) begin
      cols_setting = ebes_pkg::GRID_COLS_RST;
      rows_setting = ebes_pkg::GRID_ROWS_RST;
      grid_has_data = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ebes_pkg::REG_GRID_COLS: cols_setting = cfg_data;
          ebes_pkg::REG_GRID_ROWS: rows_setting = cfg_data[10:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (cmd == ebes_pkg::CMD_LOAD) begin
          grid_model[load_index] = load_elev_km;
          grid_has_data = 1'b1;
        end else if (!grid_has_data) begin
          pending_elev.push_back('0);
        end else begin
          pending_elev.push_back(
            predict_elevation(locate_cell(longint'(lat_rad), longint'(lon_rad))));
        end
      end
    end
  end

  always @(posedge clk) begin
    logic signed [23:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_elev.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: elev_m %0d", elev_m);
      end else begin
        want = pending_elev.pop_front();
        if (elev_m !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("elev_m mismatch: expected %0d got %0d", want, elev_m);
        end
      end
    end
  end

  // output stalls: random gaps plus one long hold per increment of holds_requested
  initial begin
    int stall_left;
    int holds_served;
    stall_left = 0;
    holds_served = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_requested) begin
        holds_served++;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0) begin
        stall_left = pick_gap(rx_gaps_on);
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic send_req(input logic op, input logic signed [18:0] la,
                          input logic signed [19:0] lo, input logic [20:0] ix,
                          input logic signed [21:0] ev);
    int gap;
    gap = pick_gap(tx_gaps_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= op;
    lat_rad      <= la;
    lon_rad      <= lo;
    load_index   <= ix;
    load_elev_km <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic send_load(input logic [20:0] ix, input logic signed [21:0] ev);
    grid_written[ix] = 1'b1;
    send_req(ebes_pkg::CMD_LOAD, 19'($urandom), 20'($urandom), ix, ev);
  endtask

  task automatic send_sample(input logic signed [18:0] la, input logic signed [19:0] lo);
    send_req(ebes_pkg::CMD_SAMPLE, la, lo, 21'($urandom), 22'($urandom));
  endtask

  // load any neighbour word not yet written, then sample
  task automatic sample_at(input logic signed [18:0] la, input logic signed [19:0] lo);
    cell_t       nb;
    logic [20:0] addr [4];
    nb = locate_cell(longint'(la), longint'(lo));
    addr[0] = nb.a00;
    addr[1] = nb.a10;
    addr[2] = nb.a01;
    addr[3] = nb.a11;
    for (int i = 0; i < 4; i++)
      if (!grid_written.exists(addr[i])) send_load(addr[i], 22'($urandom));
    send_sample(la, lo);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_elev.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_grid(input logic [11:0] cols, input logic [11:0] rows);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= ebes_pkg::REG_GRID_COLS;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_index <= ebes_pkg::REG_GRID_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_nothing_loaded();
    send_sample(19'sd0, 20'sd0);
    send_sample(19'sd262143, 20'sd524287);
    send_sample(19'sh40000, 20'sh80000);
  endtask

  // rows 0 and 1 at the top value, row 2 at the bottom value
  task automatic test_directed_corners();
    set_grid(12'd4, 12'd3);
    for (int i = 0; i < 12; i++) send_load(21'(i), (i < 8) ? ELEV_KM_MAX : ELEV_KM_MIN);
    send_load(21'h1FFFFF, 22'($urandom));
    sample_at(19'sd0, 20'sd0);
    sample_at(19'sd262143, 20'sd0);
    sample_at(19'sh40000, 20'sd0);
    sample_at(19'sd0, -20'sd205887);
    sample_at(19'sd0, -20'sd230000);
    sample_at(19'sd0, 20'sd411775);
    sample_at(19'sd0, 20'sh80000);
    sample_at(19'sd0, 20'sd524287);
    sample_at(19'sd205887, 20'sd205887);
    sample_at(-19'sd205887, -20'sd205887);
    sample_at(-19'sd1, -20'sd1);
    sample_at(19'sd102943, 20'sd300000);
  endtask

  task automatic run_phase(input logic [11:0] cols, input logic [11:0] rows, input int k);
    int start;
    set_grid(cols, rows);
    tx_gaps_on = (k % 3 != 1);
    rx_gaps_on = (k % 3 != 2);
    start = requests_sent;
    while (requests_sent - start < PHASE_REQUESTS) begin
      if ($urandom_range(99) < 25) send_load(21'($urandom), 22'($urandom));
      else sample_at(pick_lat(), pick_lon());
    end
  endtask

  task automatic test_grid_settings();
    run_phase(12'd2048, 12'd1024, 0);
    run_phase(12'd1, 12'd1, 1);
    run_phase(12'd0, 12'd0, 2);
    run_phase(12'd4095, 12'd2047, 3);
    run_phase(12'd2048, 12'd1, 4);
    run_phase(12'd1, 12'hC00, 5);
    run_phase(12'd5, 12'd3, 6);
    run_phase(12'($urandom_range(64, 1)), 12'($urandom_range(64, 1)), 7);
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // hold the output long enough for the block to fill and stall its input
  task automatic test_output_backpressure();
    set_grid(12'd6, 12'd4);
    tx_gaps_on = 1'b0;
    holds_requested++;
    repeat (40) sample_at(pick_lat(), pick_lon());
    tx_gaps_on = 1'b1;
  endtask

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    cmd          <= ebes_pkg::CMD_LOAD;
    lat_rad      <= '0;
    lon_rad      <= '0;
    load_index   <= '0;
    load_elev_km <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= ebes_pkg::REG_GRID_COLS;
    cfg_data     <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_nothing_loaded();
    test_directed_corners();
    test_grid_settings();
    test_output_backpressure();
    wait_idle();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #TIMEOUT;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
